// File: design/blc_pkg.sv
// Shared constants, codes and types for the breakpoint cell locator.
package blc_pkg;

  localparam int DefMaxDims   = 4;
  localparam int DefMaxPoints = 64;

  localparam int ValW    = 63;
  localparam int CellW   = 7;
  localparam int StatusW = 2;
  localparam int OpW     = 2;
  localparam int DimInW  = 2;

  localparam logic signed [ValW-1:0] PosInf = 63'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ValW-1:0] NegInf = -PosInf;

  localparam logic [OpW-1:0] OpClear  = 2'd0;
  localparam logic [OpW-1:0] OpInsert = 2'd1;
  localparam logic [OpW-1:0] OpLookup = 2'd2;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic                   cmp_en;
    logic                   wr_en;
    logic signed [ValW-1:0] value;
  } cell_ctl_t;

endpackage

// File: design/blc_cell.sv
// One breakpoint slot: holds entry k of every dimension, compares and shifts.
module blc_cell #(
  parameter int MAX_DIMS = blc_pkg::DefMaxDims,
  parameter int DimW     = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  blc_pkg::cell_ctl_t             ctl_i,
  input  logic [DimW-1:0]                dim_i,
  input  logic                           valid_i,
  input  logic                           left_lt_i,
  input  logic signed [blc_pkg::ValW-1:0] left_entry_i,
  output logic                           lt_o,
  output logic                           eq_o,
  output logic signed [blc_pkg::ValW-1:0] entry_o
);
  import blc_pkg::*;

  logic signed [ValW-1:0] entries_q [MAX_DIMS];
  logic                   lt_q;
  logic                   eq_q;

  assign entry_o = entries_q[dim_i];
  assign lt_o    = valid_i & lt_q;
  assign eq_o    = valid_i & eq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      lt_q <= entry_o < ctl_i.value;
      eq_q <= entry_o == ctl_i.value;
    end
  end

  // Slots at or past the insert position take the new value or their left neighbor.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && !lt_o) begin
      entries_q[dim_i] <= left_lt_i ? ctl_i.value : left_entry_i;
    end
  end

endmodule

// File: design/breakpoint_cell_locator.sv
// Top level: request decode, row of breakpoint cells, result selection and counts.
// A request is taken when start is high while busy is low. The cells compare in every
// cell at the accepting edge; then the row shifts or the bounding cells are selected
// and the result is registered. busy holds off a new request until that work is done.
// Reset clears all point counts; breakpoint contents stay undefined until inserted.
// The receiver cannot stall: done_o marks each result for exactly one cycle.
module breakpoint_cell_locator #(
  parameter int MAX_DIMS   = blc_pkg::DefMaxDims,
  parameter int MAX_POINTS = blc_pkg::DefMaxPoints
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [blc_pkg::OpW-1:0]          op_i,
  input  logic [blc_pkg::DimInW-1:0]       dim_i,
  input  logic signed [blc_pkg::ValW-1:0]  value_i,
  output logic                             done_o,
  output logic signed [blc_pkg::CellW-1:0] cell_res_o,
  output logic signed [blc_pkg::ValW-1:0]  lower_bound_o,
  output logic signed [blc_pkg::ValW-1:0]  upper_limit_o,
  output logic                             lower_open_o,
  output logic                             upper_open_o,
  output logic                             upper_inclusive_o,
  output logic [blc_pkg::StatusW-1:0]      status_o
);
  import blc_pkg::*;

  localparam int DimW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int IdxW = $clog2(MAX_POINTS);

  logic                   busy_q, done_q, dim_ok_q;
  logic [OpW-1:0]         op_q;
  logic [DimW-1:0]        dim_q;
  logic signed [ValW-1:0] value_q;
  logic [CntW-1:0]        count_q [MAX_DIMS];

  logic signed [CellW-1:0] cell_res_q, cell_res_d;
  logic signed [ValW-1:0]  lower_q, lower_d, upper_q, upper_d;
  logic                    lower_open_q, lower_open_d, upper_open_q, upper_open_d;
  logic                    upper_incl_q, upper_incl_d;
  logic [StatusW-1:0]      status_q, status_d;

  logic                   accept;
  logic [DimW-1:0]        dim_in_idx, cur_dim;
  logic                   dim_in_ok;
  logic [CntW-1:0]        count_sel;
  logic                   full, any_eq, ins_ok;
  cell_ctl_t              ctl;

  logic [MAX_POINTS-1:0]  valid, lt, eq, le, bnd, upp;
  logic [MAX_POINTS:0]    le_ext, le_left;
  logic signed [ValW-1:0] entry [MAX_POINTS];
  logic [IdxW-1:0]        idx_enc;
  logic signed [ValW-1:0] lower_sel, upper_sel;

  assign accept     = start & ~busy_q;
  assign busy       = busy_q;
  assign dim_in_idx = DimW'(dim_i);
  assign dim_in_ok  = 32'(dim_i) < MAX_DIMS;
  assign cur_dim    = busy_q ? dim_q : dim_in_idx;
  assign count_sel  = dim_ok_q ? count_q[dim_q] : '0;
  assign full       = count_sel >= CntW'(MAX_POINTS);
  assign any_eq     = |eq;
  assign ins_ok     = busy_q && (op_q == OpInsert) && dim_ok_q && !any_eq && !full;

  assign ctl.cmp_en = accept;
  assign ctl.wr_en  = ins_ok;
  assign ctl.value  = busy_q ? value_q : value_i;

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_row
    assign valid[k] = CntW'(k) < count_sel;
    blc_cell #(
      .MAX_DIMS(MAX_DIMS),
      .DimW    (DimW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .dim_i       (cur_dim),
      .valid_i     (valid[k]),
      .left_lt_i   ((k == 0) ? 1'b1 : lt[(k == 0) ? 0 : k-1]),
      .left_entry_i((k == 0) ? '0 : entry[(k == 0) ? 0 : k-1]),
      .lt_o        (lt[k]),
      .eq_o        (eq[k]),
      .entry_o     (entry[k])
    );
  end

  // Entries are sorted, so le is a thermometer; bnd marks the last cell not above
  // the value and upp the first cell above it.
  assign le      = lt | eq;
  assign le_ext  = {1'b0, le};
  assign le_left = {le, 1'b1};

  always_comb begin
    idx_enc   = '0;
    lower_sel = '0;
    upper_sel = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      bnd[k] = le[k] & ~le_ext[k+1];
      upp[k] = valid[k] & ~le[k] & le_left[k];
      if (bnd[k]) begin
        idx_enc   = idx_enc | IdxW'(k);
        lower_sel = lower_sel | entry[k];
      end
      if (upp[k]) begin
        upper_sel = upper_sel | entry[k];
      end
    end
  end

  always_comb begin
    cell_res_d   = '0;
    lower_d      = '0;
    upper_d      = '0;
    lower_open_d = 1'b0;
    upper_open_d = 1'b0;
    upper_incl_d = 1'b0;
    status_d     = StatusOk;
    unique case (op_q)
      OpInsert: begin
        if (dim_ok_q && !any_eq && full) begin
          status_d = StatusFull;
        end
      end
      OpLookup: begin
        if (count_sel == '0) begin
          cell_res_d   = '1;
          lower_d      = NegInf;
          upper_d      = PosInf;
          lower_open_d = 1'b1;
          upper_open_d = 1'b1;
          upper_incl_d = 1'b1;
          status_d     = StatusEmpty;
        end else begin
          cell_res_d   = (|bnd) ? CellW'(idx_enc) : '1;
          lower_d      = (|bnd) ? lower_sel : NegInf;
          upper_d      = (|upp) ? upper_sel : PosInf;
          lower_open_d = ~(|bnd);
          upper_open_d = ~(|upp);
          upper_incl_d = ~(|upp);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        count_q[d] <= '0;
      end
    end else begin
      done_q <= busy_q;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        if (op_q == OpClear) begin
          for (int d = 0; d < MAX_DIMS; d++) begin
            count_q[d] <= '0;
          end
        end else if (ins_ok) begin
          count_q[dim_q] <= count_sel + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      dim_q    <= dim_in_idx;
      dim_ok_q <= dim_in_ok;
      value_q  <= value_i;
    end
    if (busy_q) begin
      cell_res_q   <= cell_res_d;
      lower_q      <= lower_d;
      upper_q      <= upper_d;
      lower_open_q <= lower_open_d;
      upper_open_q <= upper_open_d;
      upper_incl_q <= upper_incl_d;
      status_q     <= status_d;
    end
  end

  assign done_o            = done_q;
  assign cell_res_o        = cell_res_q;
  assign lower_bound_o     = lower_q;
  assign upper_limit_o     = upper_q;
  assign lower_open_o      = lower_open_q;
  assign upper_open_o      = upper_open_q;
  assign upper_inclusive_o = upper_incl_q;
  assign status_o          = status_q;

  // Every request yields exactly one result, in the cycle after its work cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("result strobe missing after request");

  // At most one cell can bound a lookup value from below, and at most one from above.
  a_one_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $onehot0(bnd) && $onehot0(upp))
    else $error("more than one boundary cell");

  // A closed interior cell must have its lower limit below its upper limit.
  a_sorted_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && op_q == OpLookup && status_o == StatusOk && !lower_open_o && !upper_open_o
    |-> lower_bound_o < upper_limit_o)
    else $error("lookup cell bounds out of order");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> count_sel <= CntW'(MAX_POINTS))
    else $error("point count beyond table size");

endmodule
